// ===== sv/rgn_pkg.sv =====
`timescale 1ns / 1ps

package rgn_pkg;

  // Field widths
  localparam int CODE_W     = 32;
  localparam int TALLY_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Tally limit default; the hardware counters never pass the 16-bit maximum
  localparam longint unsigned DEF_TALLY_MAX = 64'd65535;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Allele code constants
  localparam logic [CODE_W-1:0] VEC_END = 32'h8000_0001;

  // Multiply-with-carry generator
  localparam logic [31:0] RNG_SEED = 32'd521288629;
  localparam logic [15:0] RNG_MULT = 16'd18000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_HAPLOID = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HAPLOID_SITE  = 8'd1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_ZERO_PLOIDY   = 2'd1,
    ST_HAPLOID_DENY  = 2'd2,
    ST_PLOIDY_CFG    = 2'd3
  } status_t;

  // Classified sample, front to back
  typedef struct packed {
    status_t status;
    logic    h0;
    logic    h1;
    logic    missing;
    logic    unphased;
    logic    swap;
    logic    last;
  } rgn_item_t;

  // Ploidy configuration handed to the front
  typedef struct packed {
    logic allow_haploid;
    logic haploid_site;
  } rgn_cfg_t;

endpackage

// ===== sv/rgn_if.sv =====
`timescale 1ns / 1ps

interface rgn_in_if import rgn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] first_allele_code;
  logic signed [CODE_W-1:0] second_allele_code;
  logic                     swap_ref_alt;
  logic                     last_sample;

  modport source (output valid, first_allele_code, second_allele_code, swap_ref_alt,
                  last_sample, input ready);
  modport sink   (input valid, first_allele_code, second_allele_code, swap_ref_alt,
                  last_sample, output ready);
endinterface

interface rgn_out_if import rgn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               first_hap;
  logic               second_hap;
  logic               was_missing;
  logic               was_unphased;
  logic [TALLY_W-1:0] missing_count;
  logic [TALLY_W-1:0] unphased_count;
  logic [1:0]         status;
  logic               site_done;

  modport source (output valid, first_hap, second_hap, was_missing, was_unphased,
                  missing_count, unphased_count, status, site_done, input ready);
  modport sink   (input valid, first_hap, second_hap, was_missing, was_unphased,
                  missing_count, unphased_count, status, site_done, output ready);
endinterface

interface rgn_cfg_if import rgn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rgn_front.sv =====
`timescale 1ns / 1ps

module rgn_front import rgn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rgn_in_if.sink     in_if,
  input  rgn_cfg_t   cfg,
  output logic       item_valid,
  output rgn_item_t  item,
  input  logic       item_ready
);

  function automatic logic code_missing(input logic [CODE_W-1:0] c);
    return (c[CODE_W-1:1] == '0);
  endfunction

  // signed value >= 4
  function automatic logic code_alt(input logic [CODE_W-1:0] c);
    return !c[CODE_W-1] && (c[CODE_W-2:2] != '0);
  endfunction

  logic [CODE_W-1:0] c0, c1;
  rgn_item_t         dec;
  logic              valid_r, valid_nxt;
  rgn_item_t         item_r;
  logic              take;

  assign c0 = in_if.first_allele_code;
  assign c1 = in_if.second_allele_code;

  always_comb begin
    dec          = '0;
    dec.status   = ST_OK;
    dec.swap     = in_if.swap_ref_alt;
    dec.last     = in_if.last_sample;
    if (cfg.haploid_site && !cfg.allow_haploid) begin
      dec.status = ST_PLOIDY_CFG;
    end else if (c0 == VEC_END) begin
      dec.status = ST_ZERO_PLOIDY;
    end else begin
      dec.missing = code_missing(c0);
      dec.h0      = !dec.missing && code_alt(c0);
      if (cfg.haploid_site) begin
        dec.h1 = dec.h0;
      end else if (c1 == VEC_END) begin
        if (!dec.missing) begin
          if (cfg.allow_haploid) begin
            dec.h1 = dec.h0;
          end else begin
            dec.status = ST_HAPLOID_DENY;
          end
        end
      end else if (code_missing(c1)) begin
        dec.missing = 1'b1;
      end else begin
        dec.h1       = code_alt(c1);
        dec.unphased = !c1[0];
      end
    end
    // error and missing samples carry no haplotype or phase flags
    if (dec.status != ST_OK) begin
      dec.h0       = 1'b0;
      dec.h1       = 1'b0;
      dec.missing  = 1'b0;
      dec.unphased = 1'b0;
    end else if (dec.missing) begin
      dec.h0       = 1'b0;
      dec.h1       = 1'b0;
      dec.unphased = 1'b0;
    end
  end

  assign in_if.ready = !valid_r || item_ready;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= dec;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== sv/rgn_queue.sv =====
`timescale 1ns / 1ps

module rgn_queue import rgn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  input  rgn_item_t wr_item,
  output logic      wr_ready,
  output logic      rd_valid,
  output rgn_item_t rd_item,
  input  logic      rd_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rgn_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== sv/rgn_back.sv =====
`timescale 1ns / 1ps

module rgn_back import rgn_pkg::*; #(
  parameter longint unsigned TALLY_MAX = DEF_TALLY_MAX
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  rgn_item_t item,
  output logic      item_ready,
  rgn_out_if.source out_if
);

  localparam logic [TALLY_W-1:0] TALLY_CAP =
    (TALLY_MAX > 64'd65535) ? {TALLY_W{1'b1}} : TALLY_W'(TALLY_MAX);

  logic [31:0]        rng_r, rng_nxt, rng_step;
  logic [TALLY_W-1:0] miss_r, miss_nxt, unph_r, unph_nxt;
  logic [TALLY_W-1:0] miss_cnt, unph_cnt;
  logic               out_valid_r, out_valid_nxt;
  logic               pop, ok, het;
  logic               h0, h1;

  logic               first_hap_r, second_hap_r, was_missing_r, was_unphased_r;
  logic [TALLY_W-1:0] missing_count_r, unphased_count_r;
  status_t            status_r;
  logic               site_done_r;

  function automatic logic [TALLY_W-1:0] tally_inc(input logic [TALLY_W-1:0] t);
    return (t >= TALLY_CAP) ? TALLY_CAP : t + 1'b1;
  endfunction

  assign item_ready = !out_valid_r || out_if.ready;
  assign pop        = item_valid && item_ready;

  assign ok  = (item.status == ST_OK);
  assign het = item.h0 != item.h1;

  // w = 18000 * w[15:0] + w[31:16], modulo 2^32
  assign rng_step = ({16'b0, rng_r[15:0]} * {16'b0, RNG_MULT}) + {16'b0, rng_r[31:16]};

  always_comb begin
    miss_cnt = miss_r;
    unph_cnt = unph_r;
    rng_nxt  = rng_r;
    h0       = item.h0;
    h1       = item.h1;
    if (ok) begin
      if (item.missing) begin
        miss_cnt = tally_inc(miss_r);
      end else if (item.unphased) begin
        unph_cnt = tally_inc(unph_r);
        if (het) begin
          rng_nxt = rng_step;
          if (rng_step[0]) begin
            h0 = item.h1;
            h1 = item.h0;
          end
        end
      end
      if (item.swap) begin
        h0 = !h0;
        h1 = !h1;
      end
    end
    miss_nxt = item.last ? '0 : miss_cnt;
    unph_nxt = item.last ? '0 : unph_cnt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r       <= RNG_SEED;
      miss_r      <= '0;
      unph_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        rng_r  <= rng_nxt;
        miss_r <= miss_nxt;
        unph_r <= unph_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      first_hap_r      <= h0;
      second_hap_r     <= h1;
      was_missing_r    <= item.missing;
      was_unphased_r   <= item.unphased;
      missing_count_r  <= miss_cnt;
      unphased_count_r <= unph_cnt;
      status_r         <= item.status;
      site_done_r      <= item.last;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.first_hap      = first_hap_r;
  assign out_if.second_hap     = second_hap_r;
  assign out_if.was_missing    = was_missing_r;
  assign out_if.was_unphased   = was_unphased_r;
  assign out_if.missing_count  = missing_count_r;
  assign out_if.unphased_count = unphased_count_r;
  assign out_if.status         = status_r;
  assign out_if.site_done      = site_done_r;

endmodule

// ===== sv/reference_genotype_normalizer.sv =====
`timescale 1ns / 1ps

// Reference genotype normalizer: one sample's pair of allele codes in, one
// word of haplotype bits, flags, site tallies and status out.
// Channels: in_if takes a sample word (two 32-bit allele codes, swap_ref_alt,
// last_sample); out_if returns one result word per sample, in order; cfg_if
// writes allow_haploid (index 0) and haploid_site (index 1), bit 0 of data.
// cfg_if.ready is always high; write config only while no sample is in flight.
// A word passes the front register, the queue and the output register to out_if.
// Throughput: one word per cycle while out_if is ready; the generator update
// (one 16x16 multiply and add) and the tally increment are combinational.
// Structure: front decode register -> 2-entry queue -> back end that owns the
// generator, the tallies and the output register.
// Reset: generator reloads its seed, tallies and config clear, no words held.
// Receiver stall: the output register holds its word; the queue and then the
// front register fill, after which in_if.ready drops. No word is dropped.
module reference_genotype_normalizer import rgn_pkg::*; #(
  parameter longint unsigned TALLY_MAX = DEF_TALLY_MAX
) (
  input  logic      clk,
  input  logic      rst_n,
  rgn_in_if.sink    in_if,
  rgn_out_if.source out_if,
  rgn_cfg_if.sink   cfg_if
);

  rgn_cfg_t  cfg_r, cfg_nxt;
  logic      fq_valid, fq_ready;
  rgn_item_t fq_item;
  logic      qb_valid, qb_ready;
  rgn_item_t qb_item;

  // config register file
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_ALLOW_HAPLOID: cfg_nxt.allow_haploid = cfg_if.data[0];
        REG_HAPLOID_SITE:  cfg_nxt.haploid_site  = cfg_if.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // decode and classify
  rgn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg        (cfg_r),
    .item_valid (fq_valid),
    .item       (fq_item),
    .item_ready (fq_ready)
  );

  // decouples front from back-end stalls
  rgn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_item  (fq_item),
    .wr_ready (fq_ready),
    .rd_valid (qb_valid),
    .rd_item  (qb_item),
    .rd_ready (qb_ready)
  );

  // generator, tallies, inversion, output register
  rgn_back #(
    .TALLY_MAX (TALLY_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (qb_valid),
    .item       (qb_item),
    .item_ready (qb_ready),
    .out_if     (out_if)
  );

endmodule
